[sv/saa_pkg.sv]
// Shared request, result and status types of the skyline atlas allocator.
`default_nettype none

package saa_pkg;

	// One placement request
	typedef struct packed {
		logic [8:0] rect_width;
		logic [8:0] rect_height;
	} req_t;

	// One placement result
	typedef struct packed {
		logic       atlas_index;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic       full_res;
	} res_t;

	// Status of the run tracker for the column under test
	typedef struct packed {
		logic hit;   // a free window of the requested width just completed
		logic done;  // the current threshold pass ends in this cycle
	} run_stat_t;

endpackage

`default_nettype wire

[sv/saa_run_track.sv]
// Run tracker: finds the leftmost window of columns all at or below a threshold.
`default_nettype none

module saa_run_track #(
	parameter int COLS  = 256,
	parameter int LVL_W = 9
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic [$clog2(COLS)-1:0]   in_col,
	input  wire logic [LVL_W-1:0]          in_level,
	input  wire logic [LVL_W-1:0]          thr,
	input  wire logic [8:0]                width,
	output saa_pkg::run_stat_t             stat,
	output logic      [$clog2(COLS)-1:0]   hit_x,
	output logic      [LVL_W-1:0]          hit_max
);

	localparam int CW = $clog2(COLS);
	localparam int PW = ((CW > 9) ? CW : 9) + 1;
	localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);

	logic [8:0]       run_q;
	logic [LVL_W-1:0] runmax_q;
	logic             fits;
	logic [8:0]       run_inc;
	logic [LVL_W-1:0] max_inc;
	logic [PW-1:0]    start_col;

	// column test against the threshold, running length and running max
	assign fits    = in_level <= thr;
	assign run_inc = run_q + 9'd1;
	assign max_inc = (in_level > runmax_q) ? in_level : runmax_q;

	// the run is exactly width long when it first completes, so its max is the window max
	assign stat.hit  = in_valid && fits && (run_inc == width);
	assign stat.done = stat.hit || (in_valid && (in_col == COL_LAST));

	assign start_col = PW'(in_col) + PW'(1) - PW'(width);
	assign hit_x     = start_col[CW-1:0];
	assign hit_max   = max_inc;

	// run state; restarts whenever a pass ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= '0;
			runmax_q <= '0;
		end else if (stat.done) begin
			run_q    <= '0;
			runmax_q <= '0;
		end else if (in_valid) begin
			if (fits) begin
				run_q    <= run_inc;
				runmax_q <= max_inc;
			end else begin
				run_q    <= '0;
				runmax_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

[sv/skyline_atlas_allocator_core.sv]
// Skyline atlas allocator: skyline memory, threshold search sequencer and column raise.
// Sequence: an invalid request reports full in the cycle after start. A valid request scans
//   atlases in turn with threshold passes, up to 1+ceil(log2(ATLAS_HEIGHT)) passes per atlas
//   (binary search on the level), then raises rect_width columns, one a cycle.
// Requests: one at a time; the skyline memory has a single read port. The result strobe
//   lasts one cycle; no stall.
// Reset: a clearing pass zeroes every skyline entry; busy is high.
`default_nettype none

module skyline_atlas_allocator_core #(
	parameter int NUM_ATLASES  = 2,
	parameter int ATLAS_WIDTH  = 256,
	parameter int ATLAS_HEIGHT = 256
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire saa_pkg::req_t req,
	output logic               busy,
	output logic               strobe,
	output saa_pkg::res_t      res
);

	localparam int CW    = $clog2(ATLAS_WIDTH);
	localparam int CW1   = $clog2(ATLAS_WIDTH + 1);
	localparam int HW    = $clog2(ATLAS_HEIGHT + 1);
	localparam int AW    = (NUM_ATLASES > 1) ? $clog2(NUM_ATLASES) : 1;
	localparam int ADW   = AW + CW;
	localparam int DEPTH = 1 << ADW;
	localparam int PW    = ((CW > 9) ? CW : 9) + 1;
	localparam int SW    = ((HW > 9) ? HW : 9) + 1;
	localparam int XW    = (CW > 8) ? CW : 8;
	localparam int YW    = (HW > 8) ? HW : 8;

	localparam logic [PW-1:0]  W_P     = PW'(ATLAS_WIDTH);
	localparam logic [SW-1:0]  H_S     = SW'(ATLAS_HEIGHT);
	localparam logic [CW1-1:0] COL_END = CW1'(ATLAS_WIDTH);
	localparam logic [AW-1:0]  A_LAST  = AW'(NUM_ATLASES - 1);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_RAISE = 2'd3;

	// skyline memory
	logic [HW-1:0] mem [DEPTH];
	logic [HW-1:0] rd_s1;

	logic [1:0]     state_q;
	logic [ADW-1:0] clr_q;
	logic [8:0]     w_q;
	logic [8:0]     h_q;
	logic [AW-1:0]  a_q;
	logic [HW-1:0]  top_thr_q;
	logic [HW-1:0]  thr_q;
	logic [HW-1:0]  lo_q;
	logic [HW-1:0]  hi_q;
	logic           first_q;
	logic [CW-1:0]  bx_q;
	logic [CW1-1:0] col_q;
	logic           v_s1;
	logic [CW-1:0]  c_s1;
	logic [8:0]     rc_q;
	logic           strobe_q;
	saa_pkg::res_t  res_q;

	logic           bad_req;
	logic [SW-1:0]  thr_diff;
	logic           issue;
	logic [ADW-1:0] raddr;
	logic           we;
	logic [ADW-1:0] waddr;
	logic [HW-1:0]  wdata;
	logic [PW-1:0]  raise_col;
	logic [SW-1:0]  raise_sum;
	logic [HW:0]    lo_miss_sum;
	logic [HW-1:0]  lo_miss;
	logic [HW:0]    mid_hit_sum;
	logic [HW:0]    mid_miss_sum;
	logic [XW-1:0]  bx_ext;
	logic [YW-1:0]  hi_ext;

	saa_pkg::run_stat_t stat;
	logic [CW-1:0]      hit_x;
	logic [HW-1:0]      hit_max;

	// request checks and the per-atlas top threshold
	assign bad_req  = (req.rect_width == 9'd0) || (req.rect_height == 9'd0) ||
	                  (PW'(req.rect_width) > W_P) || (SW'(req.rect_height) > H_S);
	assign thr_diff = H_S - SW'(req.rect_height);

	// read side of the scan
	assign issue = (state_q == ST_SCAN) && (col_q < COL_END);
	assign raddr = {a_q, col_q[CW-1:0]};

	// write side: clearing pass or column raise
	assign raise_col = PW'(bx_q) + PW'(rc_q);
	assign raise_sum = SW'(hi_q) + SW'(h_q);
	assign we        = (state_q == ST_CLEAR) || (state_q == ST_RAISE);
	assign waddr     = (state_q == ST_CLEAR) ? clr_q : {a_q, raise_col[CW-1:0]};
	assign wdata     = (state_q == ST_CLEAR) ? '0 : raise_sum[HW-1:0];

	// binary search arithmetic
	assign lo_miss_sum  = {1'b0, thr_q} + {{HW{1'b0}}, 1'b1};
	assign lo_miss      = lo_miss_sum[HW-1:0];
	assign mid_hit_sum  = {1'b0, lo_q} + {1'b0, hit_max};
	assign mid_miss_sum = {1'b0, lo_miss} + {1'b0, hi_q};

	assign bx_ext = XW'(bx_q);
	assign hi_ext = YW'(hi_q);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1 <= mem[raddr];
	end

	saa_run_track #(
		.COLS  (ATLAS_WIDTH),
		.LVL_W (HW)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.in_col   (c_s1),
		.in_level (rd_s1),
		.thr      (thr_q),
		.width    (w_q),
		.stat     (stat),
		.hit_x    (hit_x),
		.hit_max  (hit_max)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			w_q       <= '0;
			h_q       <= '0;
			a_q       <= '0;
			top_thr_q <= '0;
			thr_q     <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			first_q   <= 1'b0;
			bx_q      <= '0;
			col_q     <= '0;
			v_s1      <= 1'b0;
			c_s1      <= '0;
			rc_q      <= '0;
			strobe_q  <= 1'b0;
			res_q     <= '0;
		end else begin
			strobe_q <= 1'b0;
			v_s1     <= issue && !stat.done;
			c_s1     <= col_q[CW-1:0];
			if (stat.done) begin
				col_q <= '0;
			end else if (issue) begin
				col_q <= col_q + CW1'(1);
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADW'(1);
					if (clr_q == {ADW{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						w_q <= req.rect_width;
						h_q <= req.rect_height;
						if (bad_req) begin
							res_q    <= '{atlas_index: 1'b0, pos_x: 8'd0, pos_y: 8'd0,
							             full_res: 1'b1};
							strobe_q <= 1'b1;
						end else begin
							a_q       <= '0;
							top_thr_q <= thr_diff[HW-1:0];
							thr_q     <= thr_diff[HW-1:0];
							lo_q      <= '0;
							first_q   <= 1'b1;
							col_q     <= '0;
							state_q   <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (stat.done) begin
						if (stat.hit) begin
							// window found at or below thr: its max bounds the level
							hi_q    <= hit_max;
							bx_q    <= hit_x;
							first_q <= 1'b0;
							if (lo_q == hit_max) begin
								rc_q    <= '0;
								state_q <= ST_RAISE;
							end else begin
								thr_q <= mid_hit_sum[HW:1];
							end
						end else if (first_q) begin
							// nothing fits in this atlas
							if (a_q == A_LAST) begin
								res_q    <= '{atlas_index: 1'b0, pos_x: 8'd0, pos_y: 8'd0,
								             full_res: 1'b1};
								strobe_q <= 1'b1;
								state_q  <= ST_IDLE;
							end else begin
								a_q   <= a_q + AW'(1);
								thr_q <= top_thr_q;
								lo_q  <= '0;
							end
						end else begin
							// level lies above thr
							if (lo_miss == hi_q) begin
								rc_q    <= '0;
								state_q <= ST_RAISE;
							end else begin
								lo_q  <= lo_miss;
								thr_q <= mid_miss_sum[HW:1];
							end
						end
					end
				end
				ST_RAISE: begin
					rc_q <= rc_q + 9'd1;
					if (rc_q == (w_q - 9'd1)) begin
						res_q    <= '{atlas_index: a_q[0], pos_x: bx_ext[7:0],
						             pos_y: hi_ext[7:0], full_res: 1'b0};
						strobe_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = state_q != ST_IDLE;
	assign strobe = strobe_q;
	assign res    = res_q;

	// raised columns never pass the atlas height
	a_raise_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RAISE) |-> (raise_sum <= H_S))
		else $error("raise value above atlas height");

	// search bounds stay ordered once the first window is found
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && !first_q) |-> (lo_q <= hi_q))
		else $error("search bounds crossed");

	// a full result carries zero fields
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && res.full_res) |->
		((res.atlas_index == 1'b0) && (res.pos_x == 8'd0) && (res.pos_y == 8'd0)))
		else $error("full result with nonzero fields");

	// a result follows only work in progress or an accepted request
	a_strobe_cause: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ($past(busy) || $past(start)))
		else $error("result without request");

endmodule

`default_nettype wire
